// ===== rtl/core/stuffed_frame_receiver_crc16_defines.svh =====
// Assertion macros shared by the frame receiver RTL.
// Depends on nothing; the including module must have clk and arst_n in scope.
`ifndef STUFFED_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_CRC16_DEFINES_SVH

// Condition must hold whenever the antecedent holds, in the same cycle.
`define SFR_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sfr_pkg.sv =====
// Shared constants and types for the stuffed frame receiver.
// Depends on nothing; used by the CRC unit, the payload store and the top level.
package sfr_pkg;

	localparam int PAYLOAD_MAX = 64;
	localparam int ADDR_W      = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam int LEN_W       = 7;
	localparam int DLEN_HI_W   = 6;

	localparam logic [7:0]  MARK_START  = 8'h7E;
	localparam logic [7:0]  MARK_END    = 8'h7F;
	localparam logic [7:0]  MARK_ESC    = 8'h7D;
	localparam logic [7:0]  ESC_START   = 8'h5E;
	localparam logic [7:0]  ESC_ESC     = 8'h5D;
	localparam logic [7:0]  ESC_END     = 8'h5F;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	// Control word from the sequencer to the shared CRC shifter.
	typedef struct packed {
		logic init;
		logic load;
		logic shift;
	} crc_ctl_t;

endpackage

// ===== rtl/core/stuffed_frame_receiver_crc16.sv =====
// Top level of the byte-stuffed frame receiver with CRC-16/CCITT check.
// Depends on sfr_pkg, sfr_crc, sfr_store and stuffed_frame_receiver_crc16_defines.svh.
//
//   Channel | Handshake             | Fields
//   --------+-----------------------+----------------------------------------
//   rx      | rx_valid / rx_stall   | rx_byte
//   res     | res_valid / res_stall | frame_seq .. last_of_frame (six fields)
//
// A byte covered by the CRC (length, seq, flag, payload) is loaded into the CRC register
// on accept; the shared shifter then runs one bit per cycle, stalling the link. Marks,
// escapes, CRC bytes and idle bytes skip that loop; a good end mark starts the emit. A
// payload result needs a store read and an output load; an empty frame's single result
// needs only the load. A stalled output register holds the sequencer in its load step.
// Reset is asynchronous and returns the parser to waiting; the store keeps its contents.
`include "stuffed_frame_receiver_crc16_defines.svh"

module stuffed_frame_receiver_crc16 import sfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	output logic             rx_stall,
	input  logic [7:0]       rx_byte,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [7:0]       frame_seq,
	output logic [7:0]       frame_flag,
	output logic [LEN_W-1:0] frame_length,
	output logic [7:0]       payload_byte,
	output logic             byte_valid,
	output logic             last_of_frame
);

	// Frame parse phase.
	typedef enum logic [8:0] {
		PH_WAIT   = 9'b000000001,
		PH_LEN_HI = 9'b000000010,
		PH_LEN_LO = 9'b000000100,
		PH_SEQ    = 9'b000001000,
		PH_FLAG   = 9'b000010000,
		PH_DATA   = 9'b000100000,
		PH_CRC_HI = 9'b001000000,
		PH_CRC_LO = 9'b010000000,
		PH_TAIL   = 9'b100000000
	} phase_t;

	// Sequencer: idle and ready, CRC bit loop, store read, output load.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CRC  = 4'b0010,
		S_RD   = 4'b0100,
		S_LD   = 4'b1000
	} seq_t;

	seq_t                 seq_q;
	phase_t               phase_q;
	logic                 esc_q;
	logic [DLEN_HI_W-1:0] len_hi_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     bytes_rcv_q;
	logic [15:0]          rcrc_q;
	logic [7:0]           seq_held_q;
	logic [7:0]           flag_held_q;
	logic [2:0]           bit_cnt_q;
	logic [LEN_W-1:0]     emit_idx_q;

	logic                 res_valid_q;
	logic [7:0]           res_seq_q;
	logic [7:0]           res_flag_q;
	logic [LEN_W-1:0]     res_len_q;
	logic [7:0]           res_byte_q;
	logic                 res_bv_q;
	logic                 res_last_q;

	logic                 rx_take;
	logic                 is_start;
	logic                 is_end;
	logic                 is_data;
	logic [7:0]           eff_byte;
	logic                 crc_byte;
	logic [13:0]          full_len;
	logic [LEN_W-1:0]     bytes_inc;
	logic                 frame_ok;
	logic                 slot_free;
	logic                 last_emit;
	logic                 st_wr;
	logic                 st_rd;
	logic [7:0]           st_rdata;
	logic [15:0]          crc_val;
	crc_ctl_t             crc_ctl;

	assign rx_stall = (seq_q != S_IDLE);
	assign rx_take  = rx_valid && !rx_stall;

	// Mark and escape decode on the raw byte. A raw start mark clears a pending escape,
	// a raw end mark leaves it pending for the next ordinary byte.
	assign is_start = (rx_byte == MARK_START);
	assign is_end   = (rx_byte == MARK_END);
	assign is_data  = !is_start && !is_end && (esc_q || (rx_byte != MARK_ESC));

	always_comb begin
		eff_byte = rx_byte;
		if (esc_q) begin
			case (rx_byte)
				ESC_START: eff_byte = MARK_START;
				ESC_ESC:   eff_byte = MARK_ESC;
				ESC_END:   eff_byte = MARK_END;
				default:   eff_byte = rx_byte;
			endcase
		end
	end

	// Header and payload bytes are covered by the CRC; CRC bytes and idle bytes are not.
	assign crc_byte = is_data && ((phase_q == PH_LEN_HI) || (phase_q == PH_LEN_LO) ||
		(phase_q == PH_SEQ) || (phase_q == PH_FLAG) || (phase_q == PH_DATA));

	assign full_len  = {len_hi_q, eff_byte};
	assign bytes_inc = bytes_rcv_q + LEN_W'(1);
	assign frame_ok  = (phase_q == PH_TAIL) && (crc_val == rcrc_q);

	assign slot_free = !res_valid_q || !res_stall;
	assign last_emit = (len_q == '0) || ((emit_idx_q + LEN_W'(1)) == len_q);

	assign st_wr = rx_take && is_data && (phase_q == PH_DATA) && (bytes_rcv_q < len_q);
	assign st_rd = (seq_q == S_RD);

	always_comb begin
		crc_ctl       = '0;
		crc_ctl.init  = rx_take && is_start;
		crc_ctl.load  = rx_take && crc_byte;
		crc_ctl.shift = (seq_q == S_CRC);
	end

	sfr_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (eff_byte),
		.crc    (crc_val)
	);

	sfr_store u_store (
		.clk     (clk),
		.wr_en   (st_wr),
		.wr_addr (bytes_rcv_q[ADDR_W-1:0]),
		.wr_data (eff_byte),
		.rd_en   (st_rd),
		.rd_addr (emit_idx_q[ADDR_W-1:0]),
		.rd_data (st_rdata)
	);

	// Parser state, advanced once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			esc_q       <= 1'b0;
			len_hi_q    <= '0;
			len_q       <= '0;
			bytes_rcv_q <= '0;
			rcrc_q      <= '0;
			seq_held_q  <= '0;
			flag_held_q <= '0;
		end else if (rx_take) begin
			if (is_start) begin
				phase_q     <= PH_LEN_HI;
				esc_q       <= 1'b0;
				bytes_rcv_q <= '0;
			end else if (is_end) begin
				phase_q <= PH_WAIT;
			end else if (!is_data) begin
				esc_q <= 1'b1;
			end else begin
				esc_q <= 1'b0;
				case (phase_q)
					PH_LEN_HI: begin
						len_hi_q <= eff_byte[DLEN_HI_W-1:0];
						phase_q  <= PH_LEN_LO;
					end
					PH_LEN_LO: begin
						// An overlong declared length drops the frame right here.
						len_q <= full_len[LEN_W-1:0];
						if (full_len > 14'(PAYLOAD_MAX)) begin
							phase_q <= PH_WAIT;
						end else begin
							phase_q <= PH_SEQ;
						end
					end
					PH_SEQ: begin
						seq_held_q <= eff_byte;
						phase_q    <= PH_FLAG;
					end
					PH_FLAG: begin
						flag_held_q <= eff_byte;
						bytes_rcv_q <= '0;
						phase_q     <= (len_q != '0) ? PH_DATA : PH_CRC_HI;
					end
					PH_DATA: begin
						if (bytes_rcv_q < len_q) begin
							bytes_rcv_q <= bytes_inc;
							if (bytes_inc == len_q) begin
								phase_q <= PH_CRC_HI;
							end
						end else if (bytes_rcv_q == len_q) begin
							phase_q <= PH_CRC_HI;
						end
					end
					PH_CRC_HI: begin
						rcrc_q  <= {eff_byte, 8'h00};
						phase_q <= PH_CRC_LO;
					end
					PH_CRC_LO: begin
						rcrc_q  <= {rcrc_q[15:8], eff_byte};
						phase_q <= PH_TAIL;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Sequencer: the CRC bit loop after each covered byte, then the emit loop after a
	// good end mark, reading one payload entry and loading it into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= S_IDLE;
			bit_cnt_q  <= '0;
			emit_idx_q <= '0;
		end else begin
			case (seq_q)
				S_IDLE: begin
					if (rx_take && crc_byte) begin
						seq_q     <= S_CRC;
						bit_cnt_q <= '0;
					end else if (rx_take && is_end && frame_ok) begin
						emit_idx_q <= '0;
						seq_q      <= (len_q == '0) ? S_LD : S_RD;
					end
				end
				S_CRC: begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7) begin
						seq_q <= S_IDLE;
					end
				end
				S_RD: begin
					seq_q <= S_LD;
				end
				S_LD: begin
					if (slot_free) begin
						if (last_emit) begin
							seq_q <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + LEN_W'(1);
							seq_q      <= S_RD;
						end
					end
				end
				default: begin
					seq_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((seq_q == S_LD) && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((seq_q == S_LD) && slot_free) begin
			res_seq_q  <= seq_held_q;
			res_flag_q <= flag_held_q;
			res_len_q  <= len_q;
			res_byte_q <= (len_q == '0) ? 8'h00 : st_rdata;
			res_bv_q   <= (len_q != '0);
			res_last_q <= last_emit;
		end
	end

	assign res_valid     = res_valid_q;
	assign frame_seq     = res_seq_q;
	assign frame_flag    = res_flag_q;
	assign frame_length  = res_len_q;
	assign payload_byte  = res_byte_q;
	assign byte_valid    = res_bv_q;
	assign last_of_frame = res_last_q;

	`SFR_ASSERT_NEXT(a_crc_loop_ends, (seq_q == S_CRC) && (bit_cnt_q == 3'd7), seq_q == S_IDLE, "CRC bit loop ran past eight steps")
	`SFR_ASSERT_IMPLIES(a_data_count, phase_q == PH_DATA, bytes_rcv_q < len_q, "payload count reached length inside data phase")
	`SFR_ASSERT_IMPLIES(a_emit_index, seq_q == S_RD, emit_idx_q < len_q, "payload read beyond frame length")
	`SFR_ASSERT_NEXT(a_load_waits, (seq_q == S_LD) && !slot_free, (seq_q == S_LD) && res_valid_q, "result load skipped while output register full")

endmodule

// ===== rtl/core/sfr_crc.sv =====
// Bit-serial CRC-16/CCITT shifter holding the running CRC of the frame.
// Depends on sfr_pkg for the polynomial, the init value and the control struct.
module sfr_crc import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  crc_ctl_t    ctl,
	input  logic [7:0]  data,
	output logic [15:0] crc
);

	logic [15:0] crc_q;
	logic [15:0] shifted;

	assign shifted = crc_q[15] ? ({crc_q[14:0], 1'b0} ^ CRC_POLY) : {crc_q[14:0], 1'b0};
	assign crc     = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctl.load) begin
			crc_q <= crc_q ^ {data, 8'h00};
		end else if (ctl.shift) begin
			crc_q <= shifted;
		end
	end

endmodule

// ===== rtl/core/sfr_store.sv =====
// Payload store: one write port, one registered read port.
// Depends on sfr_pkg for the depth and address width.
module sfr_store import sfr_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [PAYLOAD_MAX];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== verif/sfr_tb_crc_pkg.sv =====
// CRC-16/CCITT byte fold shared by the frame builder and the frame checker.
// Depends on sfr_pkg for the polynomial.
package sfr_tb_crc_pkg;
	import sfr_pkg::*;

	// Folds one byte into the CRC, MSB first, no reflection.
	function automatic logic [15:0] crc16_ccitt_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== verif/stuffed_frame_checker.sv =====
// Checker for the stuffed frame receiver: deframes the accepted link bytes and
// compares every emitted payload request with the frame it should come from.
// Depends on sfr_pkg and sfr_tb_crc_pkg.
module stuffed_frame_checker import sfr_pkg::*, sfr_tb_crc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	input  logic             rx_stall,
	input  logic [7:0]       rx_byte,
	input  logic             res_valid,
	input  logic             res_stall,
	input  logic [7:0]       frame_seq,
	input  logic [7:0]       frame_flag,
	input  logic [LEN_W-1:0] frame_length,
	input  logic [7:0]       payload_byte,
	input  logic             byte_valid,
	input  logic             last_of_frame,
	output int               error_count,
	output int               pending
);

	typedef enum logic [3:0] {
		AWAIT_START, LEN_HI, LEN_LO, SEQ_BYTE, FLAG_BYTE, PAYLOAD, CRC_HI, CRC_LO, TAIL
	} parse_phase_t;

	typedef struct packed {
		logic [7:0]       seq;
		logic [7:0]       flag;
		logic [LEN_W-1:0] len;
		logic [7:0]       data;
		logic             data_valid;
		logic             last;
	} payload_req_t;

	parse_phase_t   phase;
	logic           esc_pending;
	logic [13:0]    decl_len;
	logic [6:0]     byte_count;
	logic [15:0]    crc_run;
	logic [15:0]    crc_seen;
	logic [7:0]     seq_held;
	logic [7:0]     flag_held;
	logic [7:0]     payload_mem [PAYLOAD_MAX];
	payload_req_t   due_payload [$];
	int             mismatches;

	initial begin
		error_count = 0;
		pending = 0;
		mismatches = 0;
	end

	// Applies one accepted link byte to the deframer and queues the payload
	// requests that an accepted end mark releases.
	task automatic deframe_byte(input logic [7:0] raw);
		logic [7:0] b;
		int n;
		payload_req_t r;
		b = raw;
		if (raw == MARK_START) begin
			phase = LEN_HI;
			esc_pending = 1'b0;
			byte_count = '0;
			crc_run = CRC_INIT;
		end else if (raw == MARK_END) begin
			if (phase == TAIL && crc_run == crc_seen) begin
				n = (decl_len > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(decl_len);
				r.seq = seq_held;
				r.flag = flag_held;
				r.len = LEN_W'(n);
				if (n == 0) begin
					r.data = 8'h00;
					r.data_valid = 1'b0;
					r.last = 1'b1;
					due_payload.push_back(r);
				end
				for (int i = 0; i < n; i++) begin
					r.data = payload_mem[i];
					r.data_valid = 1'b1;
					r.last = (i + 1 == n);
					due_payload.push_back(r);
				end
			end
			phase = AWAIT_START;
		end else if (!esc_pending && raw == MARK_ESC) begin
			esc_pending = 1'b1;
		end else begin
			if (esc_pending) begin
				if (raw == ESC_START) b = MARK_START;
				else if (raw == ESC_ESC) b = MARK_ESC;
				else if (raw == ESC_END) b = MARK_END;
				esc_pending = 1'b0;
			end
			case (phase)
				LEN_HI: begin
					decl_len = {b[DLEN_HI_W-1:0], 8'h00};
					crc_run = crc16_ccitt_fold(crc_run, b);
					phase = LEN_LO;
				end
				LEN_LO: begin
					decl_len = {decl_len[13:8], b};
					crc_run = crc16_ccitt_fold(crc_run, b);
					phase = (decl_len > PAYLOAD_MAX) ? AWAIT_START : SEQ_BYTE;
				end
				SEQ_BYTE: begin
					seq_held = b;
					crc_run = crc16_ccitt_fold(crc_run, b);
					phase = FLAG_BYTE;
				end
				FLAG_BYTE: begin
					flag_held = b;
					byte_count = '0;
					crc_run = crc16_ccitt_fold(crc_run, b);
					phase = (decl_len != 0) ? PAYLOAD : CRC_HI;
				end
				PAYLOAD: begin
					crc_run = crc16_ccitt_fold(crc_run, b);
					if (byte_count < decl_len) begin
						payload_mem[byte_count[5:0]] = b;
						byte_count = byte_count + 7'd1;
					end
					if (byte_count == decl_len) phase = CRC_HI;
				end
				CRC_HI: begin
					crc_seen = {b, 8'h00};
					phase = CRC_LO;
				end
				CRC_LO: begin
					crc_seen = {crc_seen[15:8], b};
					phase = TAIL;
				end
				default: ;
			endcase
		end
	endtask

	function automatic int field_diff(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic check_payload_req();
		payload_req_t want;
		if (due_payload.size() == 0) begin
			$error("unexpected request: seq 0x%0h, length %0d, byte 0x%0h",
				frame_seq, frame_length, payload_byte);
			mismatches++;
		end else begin
			want = due_payload.pop_front();
			mismatches += field_diff("frame_seq", want.seq, frame_seq);
			mismatches += field_diff("frame_flag", want.flag, frame_flag);
			mismatches += field_diff("frame_length", 8'(want.len), 8'(frame_length));
			mismatches += field_diff("payload_byte", want.data, payload_byte);
			mismatches += field_diff("byte_valid", 8'(want.data_valid), 8'(byte_valid));
			mismatches += field_diff("last_of_frame", 8'(want.last), 8'(last_of_frame));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = AWAIT_START;
			esc_pending = 1'b0;
			decl_len = '0;
			byte_count = '0;
			crc_run = CRC_INIT;
			crc_seen = '0;
			seq_held = '0;
			flag_held = '0;
		end else begin
			// A request can never leave in the same cycle as the end mark that
			// releases it, so taking the link byte first is safe.
			if (rx_valid && !rx_stall) deframe_byte(rx_byte);
			if (res_valid && !res_stall) check_payload_req();
		end
		pending <= due_payload.size();
		error_count <= mismatches;
	end

endmodule

// ===== verif/stuffed_frame_receiver_crc16_tb.sv =====
// Testbench top for the stuffed frame receiver: builds stuffed link traffic and
// random back-pressure, and reports the verdict from the frame checker.
// Depends on sfr_pkg, sfr_tb_crc_pkg, stuffed_frame_checker and the receiver RTL.
module stuffed_frame_receiver_crc16_tb import sfr_pkg::*, sfr_tb_crc_pkg::*;;

	// Cycles in a row with no request moving on either channel before the run
	// is declared hung. The slowest legal stretch is a payload byte through the
	// bit-serial CRC plus a full sender gap, far below this.
	localparam int STALL_LIMIT = 5000;
	// Random link bytes to send after the directed part.
	localparam int RANDOM_BYTES = 140;
	// Settling time once every expected request has arrived.
	localparam int DRAIN_CYCLES = 40;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             rx_valid = 1'b0;
	logic             rx_stall;
	logic [7:0]       rx_byte = 8'h00;
	logic             res_valid;
	logic             res_stall = 1'b1;
	logic [7:0]       frame_seq;
	logic [7:0]       frame_flag;
	logic [LEN_W-1:0] frame_length;
	logic [7:0]       payload_byte;
	logic             byte_valid;
	logic             last_of_frame;
	int               error_count;
	int               pending;

	int               bytes_sent = 0;
	int               quiet_cycles = 0;
	bit               link_idles = 1'b1;
	bit               sink_idles = 1'b1;

	always #5 clk = ~clk;

	stuffed_frame_receiver_crc16 dut (.*);

	stuffed_frame_checker frame_checker (.*);

	// Hang detection: any accepted request on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Sends one raw link byte. The sender idles for a random number of cycles
	// first, except during stretches where idling is switched off, and then
	// holds the byte until the receiver takes it.
	task automatic send_raw(input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 39) == 0) link_idles = !link_idles;
		gap = link_idles ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_byte <= b;
		rx_valid <= 1'b1;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Sends one frame byte with stuffing. The three mark values always go out
	// escaped; other bytes are sometimes escaped anyway, which the receiver
	// must pass through unchanged. The escape codes themselves are never
	// escaped needlessly, since that would turn them into marks.
	task automatic put_data(input logic [7:0] b);
		if (b == MARK_START || b == MARK_ESC || b == MARK_END) begin
			send_raw(MARK_ESC);
			send_raw(b ^ 8'h20);
		end else if ($urandom_range(0, 15) == 0 && b != ESC_START && b != ESC_ESC &&
				b != ESC_END) begin
			send_raw(MARK_ESC);
			send_raw(b);
		end else begin
			send_raw(b);
		end
	endtask

	// Builds and sends one frame: start mark, length (with the two unused top
	// bits of the high byte set as given), seq, flag, random payload and CRC,
	// then the end mark. A cut at or above zero ends the frame with an end mark
	// after that many body bytes. Tail junk bytes sit between CRC and end mark.
	// For a length above the store, a few filler bytes stand in for payload.
	task automatic send_frame(input logic [13:0] len, input logic [1:0] hi_top,
			input logic [7:0] seq, input logic [7:0] flag, input bit bad_crc,
			input int cut, input int tail_junk);
		logic [7:0]  body [$];
		logic [15:0] crc;
		int          n_data;
		body.push_back({hi_top, len[13:8]});
		body.push_back(len[7:0]);
		body.push_back(seq);
		body.push_back(flag);
		n_data = (len <= PAYLOAD_MAX) ? int'(len) : $urandom_range(0, 4);
		repeat (n_data) body.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (body[i]) crc = crc16_ccitt_fold(crc, body[i]);
		if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(0, 15));
		send_raw(MARK_START);
		for (int i = 0; i < body.size() && i != cut; i++) begin
			put_data(body[i]);
		end
		if (cut < 0) begin
			put_data(crc[15:8]);
			put_data(crc[7:0]);
			repeat (tail_junk) put_data(8'($urandom));
		end
		send_raw(MARK_END);
	endtask

	// Result side: stalls for a random number of cycles per request, with
	// stretches of no stalling, then takes the next request.
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) sink_idles = !sink_idles;
			hold = sink_idles ? $urandom_range(0, 13) : 0;
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// Link side: reset, directed corner cases, then random traffic.
	initial begin
		int         kind;
		int         stop_at;
		logic [13:0] len;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle bytes at the extremes while waiting for a start mark.
		send_raw(8'h00);
		send_raw(8'hFF);
		// Empty frame with the unused length bits set; it must give exactly
		// one request with no data byte.
		send_frame(14'd0, 2'b11, 8'hFF, 8'h00, 1'b0, -1, 0);
		// End mark straight after a start mark: not in tail, no result.
		send_frame(14'd0, 2'b00, 8'h00, 8'h00, 1'b0, 0, 0);
		// Length one above the store: the frame is dropped after the low
		// length byte, and the end mark finds the parser already waiting.
		send_frame(14'(PAYLOAD_MAX + 1), 2'b00, 8'h00, 8'h00, 1'b0, 2, 0);
		// An escape survives an end mark and then applies to the next byte,
		// which is ignored while waiting.
		send_raw(MARK_ESC);
		send_raw(MARK_END);
		send_raw(ESC_START);
		// A pending escape is cleared by the start mark of the next frame,
		// which also carries one junk byte in its tail.
		send_raw(MARK_ESC);
		send_frame(14'd1, 2'b00, 8'h00, 8'hFF, 1'b0, -1, 1);
		// Good framing but a CRC that does not match: no result.
		send_frame(14'd0, 2'b00, 8'h5A, 8'hA5, 1'b1, -1, 0);

		// One frame at the full store size, then mostly short frames.
		stop_at = bytes_sent + RANDOM_BYTES;
		send_frame(14'(PAYLOAD_MAX), 2'($urandom), 8'($urandom), 8'($urandom), 1'b0, -1, 0);
		while (bytes_sent < stop_at) begin
			kind = $urandom_range(0, 15);
			len = ($urandom_range(0, 19) == 0) ? 14'($urandom_range(0, PAYLOAD_MAX)) :
				14'($urandom_range(0, 6));
			if (kind < 11) begin
				send_frame(len, 2'($urandom), 8'($urandom), 8'($urandom), 1'b0, -1,
					($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
			end else if (kind == 11) begin
				send_frame(len, 2'($urandom), 8'($urandom), 8'($urandom), 1'b1, -1, 0);
			end else if (kind == 12) begin
				// End mark somewhere inside the header or payload.
				send_frame(len, 2'($urandom), 8'($urandom), 8'($urandom), 1'b0,
					$urandom_range(0, 3 + int'(len)), 0);
			end else if (kind == 13) begin
				len = 14'($urandom_range(PAYLOAD_MAX + 1, 16383));
				send_frame(len, 2'($urandom), 8'($urandom), 8'($urandom), 1'b0, -1, 0);
			end else if (kind == 14) begin
				// Raw line noise, marks included.
				repeat ($urandom_range(1, 6)) send_raw(8'($urandom));
			end else begin
				// Stuffed filler between frames.
				repeat ($urandom_range(1, 3)) put_data(8'($urandom));
			end
		end

		rx_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
